>>> hw/rtl/skpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skpe_pkg
// Shared widths, codes and types for the sorted key page engine.
// ----------------------------------------------------------------------------
package skpe_pkg;

    localparam int KEY_W             = 32;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int KIND_W            = 2;
    localparam int POS_W             = 4;
    localparam int LIMIT_W           = 3;
    localparam int PAGE_CAPACITY_DEF = 8;

    localparam logic [LIMIT_W-1:0] FULL_LIMIT_RESET = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_SPLIT  = 2'd2,
        OP_NONE   = 2'd3
    } skpe_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NO_GREATER = 2'd2,
        STATUS_EMPTY    = 2'd3
    } skpe_status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK       = 2'd0,
        KIND_HIT       = 2'd1,
        KIND_SEPARATOR = 2'd2,
        KIND_UPPER     = 2'd3
    } skpe_kind_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_SPLIT = 1'b1
    } skpe_state_t;

    // Command from the controller to the row of key cells.
    typedef struct packed {
        logic                    ins_en;
        logic signed [KEY_W-1:0] probe_key;
    } skpe_probe_t;

    // First stored key strictly greater than the probe key.
    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] key;
    } skpe_hit_t;

endpackage
`default_nettype wire

>>> hw/rtl/skpe_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skpe_cell
// One key slot of the page: compares its key with the probe and shifts on
// insert, taking its lower neighbor's key or the new key.
// ----------------------------------------------------------------------------
module skpe_cell
    import skpe_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    occupied,
    input  wire logic                    at_tail,
    input  wire logic                    prev_gt,
    input  wire logic signed [KEY_W-1:0] prev_key,
    input  wire skpe_probe_t             probe,
    output logic                         gt,
    output logic signed [KEY_W-1:0]      key_q
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign gt    = occupied && (key_reg > probe.probe_key);
    assign key_q = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (probe.ins_en)
        begin
            // Everything above the insertion point moves up by one slot.
            if (prev_gt)
            begin
                key_next = prev_key;
            end
            else if (gt || at_tail)
            begin
                key_next = probe.probe_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/skpe_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skpe_chain
// Row of key cells holding the sorted page, with the first-greater detector
// and the read select used while a split streams out.
// ----------------------------------------------------------------------------
module skpe_chain
    import skpe_pkg::*;
#(
    parameter int PAGE_CAPACITY = PAGE_CAPACITY_DEF,
    parameter int IDX_W         = $clog2(PAGE_CAPACITY),
    parameter int CNT_W         = $clog2(PAGE_CAPACITY + 1)
)
(
    input  wire logic              clk,
    input  wire logic [CNT_W-1:0]  count,
    input  wire skpe_probe_t       probe,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output skpe_hit_t              hit,
    output logic [IDX_W-1:0]       hit_pos,
    output logic signed [KEY_W-1:0] rd_key
);

    logic [PAGE_CAPACITY-1:0] gt;
    logic [PAGE_CAPACITY-1:0] first;
    logic signed [KEY_W-1:0]  key_q [PAGE_CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < PAGE_CAPACITY; gi++)
        begin : g_cell
            logic                    prev_gt;
            logic signed [KEY_W-1:0] prev_key;

            if (gi == 0)
            begin : g_head
                assign prev_gt  = 1'b0;
                assign prev_key = '0;
            end
            else
            begin : g_body
                assign prev_gt  = gt[gi-1];
                assign prev_key = key_q[gi-1];
            end

            // Keys are ascending, so the greater flags form a run at the top
            // of the occupied slots; its lowest member is the answer.
            assign first[gi] = gt[gi] && !prev_gt;

            skpe_cell u_cell
            (
                .clk      (clk),
                .occupied (CNT_W'(gi) < count),
                .at_tail  (CNT_W'(gi) == count),
                .prev_gt  (prev_gt),
                .prev_key (prev_key),
                .probe    (probe),
                .gt       (gt[gi]),
                .key_q    (key_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit     = '0;
        hit_pos = '0;
        rd_key  = '0;
        for (int i = 0; i < PAGE_CAPACITY; i++)
        begin
            if (first[i])
            begin
                hit.found = 1'b1;
                hit.key   = hit.key | key_q[i];
                hit_pos   = hit_pos | IDX_W'(i);
            end
            if (rd_idx == IDX_W'(i))
            begin
                rd_key = rd_key | key_q[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_key_page_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_page_engine
// One sorted page of signed keys with insert, first-greater search and split.
//
// Input beats (opcode, key) are taken when in_valid is high and in_stall is
// low. Insert and search each produce one registered result beat, in the cycle
// after the input beat. Insert shifts the row of key cells in that same cycle,
// so a new input can be taken every cycle while the output register drains.
// Split answers an empty page at once; otherwise it emits one beat per key
// (the separator, then the upper keys), reading one cell a cycle while the
// output is not stalled, through the row's read select, and takes no input until
// its last beat has been loaded. Opcode 3 is accepted and produces nothing.
// A result beat waits in the output register while out_stall is high; the
// input then stalls as well. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) is always ready and sets the page-full threshold.
// Reset empties the page, sets the threshold to 6 and drops any pending beat.
// ----------------------------------------------------------------------------
module sorted_key_page_engine
    import skpe_pkg::*;
#(
    parameter int PAGE_CAPACITY = PAGE_CAPACITY_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic signed [KEY_W-1:0] key,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic [KIND_W-1:0]            result_kind,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [POS_W-1:0]             position,
    output logic [POS_W-1:0]             key_count,
    output logic                         page_full,
    output logic                         last,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [LIMIT_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(PAGE_CAPACITY);
    localparam int CNT_W = $clog2(PAGE_CAPACITY + 1);

    skpe_state_t              state_reg;
    skpe_state_t              state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [IDX_W-1:0]         rd_reg;
    logic [IDX_W-1:0]         rd_next;
    logic [IDX_W-1:0]         center_reg;
    logic [IDX_W-1:0]         center_next;
    logic [CNT_W-1:0]         end_reg;
    logic [CNT_W-1:0]         end_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [KIND_W-1:0]        kind_next;
    logic signed [KEY_W-1:0]  okey_reg;
    logic signed [KEY_W-1:0]  okey_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [POS_W-1:0]         kcnt_reg;
    logic [POS_W-1:0]         kcnt_next;
    logic                     full_reg;
    logic                     full_next;
    logic                     last_reg;
    logic                     last_next;

    logic                     slot_free;
    logic                     in_acc;
    logic                     page_at_cap;
    logic                     split_last;
    skpe_op_t                 op;
    skpe_probe_t              probe;
    skpe_hit_t                hit;
    logic [IDX_W-1:0]         hit_pos;
    logic signed [KEY_W-1:0]  rd_key;

    assign op          = skpe_op_t'(opcode);
    assign slot_free   = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != S_IDLE) || !slot_free;
    assign in_acc      = in_valid && !in_stall;
    assign page_at_cap = count_reg >= CNT_W'(PAGE_CAPACITY);
    assign split_last  = (CNT_W'(rd_reg) + CNT_W'(1)) == end_reg;
    assign cfg_ready   = 1'b1;

    assign probe.ins_en    = in_acc && (op == OP_INSERT) && !page_at_cap;
    assign probe.probe_key = key;

    skpe_chain #(
        .PAGE_CAPACITY (PAGE_CAPACITY),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_chain (
        .clk     (clk),
        .count   (count_reg),
        .probe   (probe),
        .rd_idx  (rd_reg),
        .hit     (hit),
        .hit_pos (hit_pos),
        .rd_key  (rd_key)
    );

    // Next state, page count and split pointers.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        center_next = center_reg;
        end_next    = end_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (probe.ins_en)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (in_acc && (op == OP_SPLIT) && (count_reg != '0))
                begin
                    state_next  = S_SPLIT;
                    count_next  = count_reg >> 1;
                    rd_next     = IDX_W'(count_reg >> 1);
                    center_next = IDX_W'(count_reg >> 1);
                    end_next    = count_reg;
                end
            end
            S_SPLIT:
            begin
                if (slot_free)
                begin
                    rd_next = rd_reg + IDX_W'(1);
                    if (split_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register contents.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        kind_next      = kind_reg;
        okey_next      = okey_reg;
        pos_next       = pos_reg;
        kcnt_next      = kcnt_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (op != OP_NONE))
                begin
                    out_valid_next = 1'b1;
                    kcnt_next      = POS_W'(count_next);
                    full_next      = 32'(count_next) > 32'(limit_reg);
                    last_next      = 1'b1;
                    pos_next       = '0;
                    okey_next      = '0;
                    status_next    = STATUS_OK;
                    unique case (op)
                        OP_INSERT:
                        begin
                            kind_next = KIND_ACK;
                            okey_next = key;
                            if (page_at_cap)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (hit.found)
                            begin
                                pos_next = POS_W'(hit_pos);
                            end
                            else
                            begin
                                pos_next = POS_W'(count_reg);
                            end
                        end
                        OP_SEARCH:
                        begin
                            kind_next = KIND_HIT;
                            if (hit.found)
                            begin
                                okey_next = hit.key;
                                pos_next  = POS_W'(hit_pos);
                            end
                            else
                            begin
                                status_next = STATUS_NO_GREATER;
                            end
                        end
                        default:
                        begin
                            // Split: a non-empty page streams from S_SPLIT.
                            kind_next = KIND_SEPARATOR;
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SPLIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    kind_next      = (rd_reg == center_reg) ? KIND_SEPARATOR : KIND_UPPER;
                    okey_next      = rd_key;
                    pos_next       = POS_W'(rd_reg);
                    kcnt_next      = POS_W'(count_reg);
                    full_next      = 32'(count_reg) > 32'(limit_reg);
                    last_next      = split_last;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= FULL_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        center_reg <= center_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        okey_reg   <= okey_next;
        pos_reg    <= pos_next;
        kcnt_reg   <= kcnt_next;
        full_reg   <= full_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_kind = kind_reg;
    assign out_key     = okey_reg;
    assign position    = pos_reg;
    assign key_count   = kcnt_reg;
    assign page_full   = full_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire
